// ===== sv/cliu_pkg.sv =====
// ----------------------------------------------------------------------------
// cliu_pkg: shared types and constants of the load instruction execute unit
// Decoded item format, result format, register file view and opcode names.
// ----------------------------------------------------------------------------
package cliu_pkg;

  // Default depth of the queue between the decoder and the execute stage.
  localparam int unsigned QDEPTH = 2;

  // Stream widths, whole bytes.
  localparam int unsigned IN_W   = 32;
  localparam int unsigned OUT_W  = 112;

  // Register codes as they appear in the opcode (B C D E H L (HL) A).
  localparam logic [2:0] REG_B     = 3'd0;
  localparam logic [2:0] REG_C     = 3'd1;
  localparam logic [2:0] REG_D     = 3'd2;
  localparam logic [2:0] REG_E     = 3'd3;
  localparam logic [2:0] REG_H     = 3'd4;
  localparam logic [2:0] REG_L     = 3'd5;
  localparam logic [2:0] REG_HLIND = 3'd6;
  localparam logic [2:0] REG_A     = 3'd7;

  // Pair codes of LD rr,d16; the remaining code selects SP.
  localparam logic [1:0] PAIR_BC = 2'd0;
  localparam logic [1:0] PAIR_DE = 2'd1;
  localparam logic [1:0] PAIR_HL = 2'd2;

  // Opcodes outside the regular LD groups.
  localparam logic [7:0] OP_HALT      = 8'h76;
  localparam logic [7:0] OP_LD_A16_SP = 8'h08;
  localparam logic [7:0] OP_LDH_N_A   = 8'he0;
  localparam logic [7:0] OP_LDH_A_N   = 8'hf0;
  localparam logic [7:0] OP_LD_C_A    = 8'he2;
  localparam logic [7:0] OP_LD_A_C    = 8'hf2;
  localparam logic [7:0] OP_LD_A16_A  = 8'hea;
  localparam logic [7:0] OP_LD_A_A16  = 8'hfa;
  localparam logic [7:0] OP_LD_HL_SPS = 8'hf8;
  localparam logic [7:0] OP_LD_SP_HL  = 8'hf9;

  // Low nibbles of the 16-bit and indirect accumulator groups.
  localparam logic [3:0] NIB_LD_RR_D16 = 4'h1;
  localparam logic [3:0] NIB_ST_IND_A  = 4'h2;
  localparam logic [3:0] NIB_LD_A_IND  = 4'ha;
  localparam logic [2:0] SRC_D8        = 3'd6;

  localparam logic [7:0] HIGH_PAGE    = 8'hff;
  localparam logic [4:0] CYC_SP_STORE = 5'd20;

  typedef enum logic [3:0] {
    KD_RET,    // read data for the pending load
    KD_MOV,    // register to register
    KD_IMM8,   // register from d8
    KD_IMM16,  // pair from d16
    KD_WR,     // single byte store
    KD_RD,     // single byte load, leaves a read pending
    KD_SPST,   // SP stored as two bytes
    KD_HLSP,   // HL = SP + s8
    KD_SPHL    // SP = HL
  } kind_e;

  typedef enum logic [2:0] {
    AS_BC  = 3'd0,
    AS_DE  = 3'd1,
    AS_HLI = 3'd2,
    AS_HLD = 3'd3,
    AS_HL  = 3'd4,
    AS_HIO = 3'd5,  // FF00 + a8
    AS_HIC = 3'd6,  // FF00 + C
    AS_A16 = 3'd7
  } asrc_e;

  typedef enum logic [1:0] {
    BOP_NONE = 2'd0,
    BOP_RD   = 2'd1,
    BOP_WR   = 2'd2
  } bus_op_e;

  typedef struct packed {
    kind_e       kind;
    logic [2:0]  dst;
    logic [2:0]  src;
    asrc_e       asrc;
    logic [1:0]  pair;
    logic        use_imm;
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic [7:0]  rdata;
    logic [4:0]  cyc;
    logic [1:0]  len;
  } dec_t;

  typedef struct packed {
    logic [7:0]  a;
    logic [3:0]  f;   // Z N H C
    logic [15:0] bc;
    logic [15:0] de;
    logic [15:0] hl;
    logic [15:0] sp;
  } regs_t;

  typedef struct packed {
    bus_op_e     bus_op;
    logic [15:0] addr;
    logic [7:0]  wdata;
    regs_t       regs;
    logic [4:0]  t_cycles;
    logic [1:0]  instr_len;
    logic        last;
  } res_t;

endpackage

// ===== sv/cliu_front.sv =====
// ----------------------------------------------------------------------------
// cliu_front: input side of the load instruction execute unit
// Accepts items, decodes the opcode and pushes load work into the queue.
// ----------------------------------------------------------------------------
module cliu_front (
  input  logic                 s_valid_i,
  output logic                 s_ready_o,
  input  logic [31:0]          s_data_i,
  input  logic                 s_user_i,
  input  logic                 full_i,
  output logic                 push_o,
  output cliu_pkg::dec_t       push_data_o
);
  import cliu_pkg::*;

  logic [7:0] op;
  logic       keep;
  dec_t       dec;

  assign op = s_data_i[7:0];

  always_comb begin
    dec       = '0;
    dec.kind  = KD_MOV;
    dec.asrc  = AS_HL;
    dec.lo    = s_data_i[15:8];
    dec.hi    = s_data_i[23:16];
    dec.rdata = s_data_i[31:24];
    dec.dst   = op[5:3];
    dec.src   = op[2:0];
    dec.pair  = op[5:4];
    keep      = 1'b1;
    if (s_user_i) begin
      dec.kind = KD_RET;
    end else if (op[7:6] == 2'b01 && op != OP_HALT) begin
      dec.len = 2'd1;
      dec.cyc = 5'd8;
      if (op[2:0] == REG_HLIND) begin
        dec.kind = KD_RD;
      end else if (op[5:3] == REG_HLIND) begin
        dec.kind = KD_WR;
      end else begin
        dec.kind = KD_MOV;
        dec.cyc  = 5'd4;
      end
    end else if (op[7:6] == 2'b00 && op[2:0] == SRC_D8) begin
      dec.len = 2'd2;
      if (op[5:3] == REG_HLIND) begin
        dec.kind    = KD_WR;
        dec.use_imm = 1'b1;
        dec.cyc     = 5'd12;
      end else begin
        dec.kind = KD_IMM8;
        dec.cyc  = 5'd8;
      end
    end else if (op[7:6] == 2'b00 && op[3:0] == NIB_LD_RR_D16) begin
      dec.kind = KD_IMM16;
      dec.cyc  = 5'd12;
      dec.len  = 2'd3;
    end else if (op[7:6] == 2'b00 && op[3:0] == NIB_ST_IND_A) begin
      dec.kind = KD_WR;
      dec.asrc = asrc_e'({1'b0, op[5:4]});
      dec.src  = REG_A;
      dec.cyc  = 5'd8;
      dec.len  = 2'd1;
    end else if (op[7:6] == 2'b00 && op[3:0] == NIB_LD_A_IND) begin
      dec.kind = KD_RD;
      dec.asrc = asrc_e'({1'b0, op[5:4]});
      dec.dst  = REG_A;
      dec.cyc  = 5'd8;
      dec.len  = 2'd1;
    end else begin
      dec.src = REG_A;
      dec.dst = REG_A;
      unique case (op)
        OP_LD_A16_SP: begin
          dec.kind = KD_SPST; dec.cyc = CYC_SP_STORE; dec.len = 2'd3;
        end
        OP_LDH_N_A: begin
          dec.kind = KD_WR; dec.asrc = AS_HIO; dec.cyc = 5'd12; dec.len = 2'd2;
        end
        OP_LDH_A_N: begin
          dec.kind = KD_RD; dec.asrc = AS_HIO; dec.cyc = 5'd12; dec.len = 2'd2;
        end
        OP_LD_C_A: begin
          dec.kind = KD_WR; dec.asrc = AS_HIC; dec.cyc = 5'd8; dec.len = 2'd1;
        end
        OP_LD_A_C: begin
          dec.kind = KD_RD; dec.asrc = AS_HIC; dec.cyc = 5'd8; dec.len = 2'd1;
        end
        OP_LD_A16_A: begin
          dec.kind = KD_WR; dec.asrc = AS_A16; dec.cyc = 5'd16; dec.len = 2'd3;
        end
        OP_LD_A_A16: begin
          dec.kind = KD_RD; dec.asrc = AS_A16; dec.cyc = 5'd16; dec.len = 2'd3;
        end
        OP_LD_HL_SPS: begin
          dec.kind = KD_HLSP; dec.cyc = 5'd12; dec.len = 2'd2;
        end
        OP_LD_SP_HL: begin
          dec.kind = KD_SPHL; dec.cyc = 5'd8; dec.len = 2'd1;
        end
        default: keep = 1'b0;
      endcase
    end
  end

  // Opcodes outside the LD group are consumed here and never queued.
  assign s_ready_o   = !full_i;
  assign push_o      = s_valid_i && !full_i && keep;
  assign push_data_o = dec;

endmodule

// ===== sv/cliu_queue.sv =====
// ----------------------------------------------------------------------------
// cliu_queue: short FIFO of decoded items
// Decouples the decoder from the execute stage so that each may stall alone.
// ----------------------------------------------------------------------------
module cliu_queue #(
  parameter int unsigned Depth = cliu_pkg::QDEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  cliu_pkg::dec_t       push_data_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 head_vld_o,
  output cliu_pkg::dec_t       head_o
);
  import cliu_pkg::*;

  localparam int unsigned PW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  dec_t            mem_q [Depth];
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            do_pop;

  assign full_o     = (cnt_q == CW'(Depth));
  assign head_vld_o = (cnt_q != '0);
  assign head_o     = mem_q[rd_ptr_q];
  assign do_pop     = pop_i && head_vld_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(Depth - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(Depth - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== sv/cliu_back.sv =====
// ----------------------------------------------------------------------------
// cliu_back: execute stage of the load instruction execute unit
// Holds the register file, carries out queued loads and drives the result.
// ----------------------------------------------------------------------------
module cliu_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 head_vld_i,
  input  cliu_pkg::dec_t       head_i,
  output logic                 pop_o,
  output logic                 res_vld_o,
  output cliu_pkg::res_t       res_o,
  input  logic                 res_ready_i
);
  import cliu_pkg::*;

  function automatic logic [7:0] get_r(regs_t r, logic [2:0] code);
    logic [7:0] v;
    case (code)
      REG_B:   v = r.bc[15:8];
      REG_C:   v = r.bc[7:0];
      REG_D:   v = r.de[15:8];
      REG_E:   v = r.de[7:0];
      REG_H:   v = r.hl[15:8];
      REG_L:   v = r.hl[7:0];
      REG_A:   v = r.a;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic regs_t set_r(regs_t r, logic [2:0] code, logic [7:0] v);
    regs_t n;
    n = r;
    case (code)
      REG_B:   n.bc[15:8] = v;
      REG_C:   n.bc[7:0]  = v;
      REG_D:   n.de[15:8] = v;
      REG_E:   n.de[7:0]  = v;
      REG_H:   n.hl[15:8] = v;
      REG_L:   n.hl[7:0]  = v;
      REG_A:   n.a        = v;
      default: n          = r;
    endcase
    return n;
  endfunction

  regs_t       regs_q, regs_d;
  logic        wait_q, wait_d;
  logic [2:0]  tgt_q, tgt_d;
  logic        phase_q, phase_d;
  logic        out_vld_q, out_vld_d;
  res_t        out_q, out_d;

  logic        adv;
  logic        emit;
  res_t        res;
  logic [15:0] a16;
  logic [15:0] addr;
  logic [15:0] hl_new;
  logic [7:0]  wsrc;
  logic [4:0]  half_sum;
  logic [8:0]  byte_sum;

  assign a16      = {head_i.hi, head_i.lo};
  assign wsrc     = head_i.use_imm ? head_i.lo : get_r(regs_q, head_i.src);
  assign half_sum = {1'b0, regs_q.sp[3:0]} + {1'b0, head_i.lo[3:0]};
  assign byte_sum = {1'b0, regs_q.sp[7:0]} + {1'b0, head_i.lo};

  // Address formation, with the HL post-increment and post-decrement.
  always_comb begin
    hl_new = regs_q.hl;
    unique case (head_i.asrc)
      AS_BC:  addr = regs_q.bc;
      AS_DE:  addr = regs_q.de;
      AS_HLI: begin addr = regs_q.hl; hl_new = regs_q.hl + 16'd1; end
      AS_HLD: begin addr = regs_q.hl; hl_new = regs_q.hl - 16'd1; end
      AS_HL:  addr = regs_q.hl;
      AS_HIO: addr = {HIGH_PAGE, head_i.lo};
      AS_HIC: addr = {HIGH_PAGE, regs_q.bc[7:0]};
      AS_A16: addr = a16;
      default: addr = regs_q.hl;
    endcase
  end

  always_comb begin
    regs_d    = regs_q;
    wait_d    = wait_q;
    tgt_d     = tgt_q;
    phase_d   = phase_q;
    out_d     = out_q;
    out_vld_d = out_vld_q && !res_ready_i;
    pop_o     = 1'b0;
    emit      = 1'b0;
    res       = '0;
    adv       = !out_vld_q || res_ready_i;

    if (adv && head_vld_i) begin
      if (head_i.kind == KD_RET) begin
        pop_o = 1'b1;
        if (wait_q) begin
          regs_d   = set_r(regs_q, tgt_q, head_i.rdata);
          wait_d   = 1'b0;
          emit     = 1'b1;
          res.last = 1'b1;
        end
      end else if (head_i.kind == KD_SPST) begin
        // The entry stays at the head until both bytes have gone out.
        emit          = 1'b1;
        res.bus_op    = BOP_WR;
        res.t_cycles  = head_i.cyc;
        res.instr_len = head_i.len;
        if (!phase_q) begin
          res.addr  = a16;
          res.wdata = regs_q.sp[7:0];
          phase_d   = 1'b1;
        end else begin
          res.addr  = a16 + 16'd1;
          res.wdata = regs_q.sp[15:8];
          res.last  = 1'b1;
          phase_d   = 1'b0;
          wait_d    = 1'b0;
          pop_o     = 1'b1;
        end
      end else begin
        pop_o         = 1'b1;
        emit          = 1'b1;
        res.last      = 1'b1;
        res.t_cycles  = head_i.cyc;
        res.instr_len = head_i.len;
        wait_d        = 1'b0;
        unique case (head_i.kind)
          KD_MOV:  regs_d = set_r(regs_q, head_i.dst, get_r(regs_q, head_i.src));
          KD_IMM8: regs_d = set_r(regs_q, head_i.dst, head_i.lo);
          KD_IMM16: begin
            unique case (head_i.pair)
              PAIR_BC: regs_d.bc = a16;
              PAIR_DE: regs_d.de = a16;
              PAIR_HL: regs_d.hl = a16;
              default: regs_d.sp = a16;
            endcase
          end
          KD_WR: begin
            res.bus_op = BOP_WR;
            res.addr   = addr;
            res.wdata  = wsrc;
            regs_d.hl  = hl_new;
          end
          KD_RD: begin
            res.bus_op = BOP_RD;
            res.addr   = addr;
            regs_d.hl  = hl_new;
            wait_d     = 1'b1;
            tgt_d      = head_i.dst;
          end
          KD_HLSP: begin
            regs_d.hl = regs_q.sp + {{8{head_i.lo[7]}}, head_i.lo};
            regs_d.f  = {2'b00, half_sum[4], byte_sum[8]};
          end
          KD_SPHL: regs_d.sp = regs_q.hl;
          default: regs_d = regs_q;
        endcase
      end
    end

    res.regs = regs_d;
    if (emit) begin
      out_d     = res;
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q    <= '0;
      wait_q    <= 1'b0;
      tgt_q     <= '0;
      phase_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      regs_q    <= regs_d;
      wait_q    <= wait_d;
      tgt_q     <= tgt_d;
      phase_q   <= phase_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign res_vld_o = out_vld_q;
  assign res_o     = out_q;

endmodule

// ===== sv/cpu_load_instruction_execute_unit.sv =====
// ----------------------------------------------------------------------------
// cpu_load_instruction_execute_unit: LD group execute unit of an 8-bit CPU
// Top level: decoder, item queue and execute stage with the register file.
// ----------------------------------------------------------------------------
// The unit keeps A, F, BC, DE, HL and SP and executes the LD instructions of
// an SM83-style CPU. Each input item is either an instruction (tuser low) with
// its opcode and immediate bytes, or the byte returned for the read that the
// last load left pending (tuser high). The unit takes one item per cycle while
// the queue has room and gives one result per cycle while the output side is
// not stalled; an item passes through the queue and its result through the
// output register. LD (a16),SP is the one instruction with two results, low
// byte then high byte; it holds the execute stage until both bytes have gone
// out. Opcodes outside the LD group, HALT among them, are dropped by the
// decoder and give no result; a read-data item with no read pending is taken
// and gives no result. A load that reads memory shows any HL step in its read
// request; the target register is written when the data item comes back, and
// a new load issued first drops the pending one. A short queue between the
// decoder and the execute stage, and a register on the output, let the input
// keep flowing while a result waits to be taken.
module cpu_load_instruction_execute_unit #(
  parameter int unsigned QueueDepth = cliu_pkg::QDEPTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Input items.
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // opcode [7:0], imm_lo [15:8], imm_hi [23:16], read_data [31:24]
  input  logic [cliu_pkg::IN_W-1:0]   s_axis_tdata_i,
  // req_type [0]
  input  logic                        s_axis_tuser_i,
  // Result items.
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  // bus_addr [15:0], bus_wdata [23:16], reg_a [31:24], reg_f [39:32],
  // reg_bc [55:40], reg_de [71:56], reg_hl [87:72], reg_sp [103:88],
  // t_cycles [108:104], instr_len [110:109], zero [111]
  output logic [cliu_pkg::OUT_W-1:0]  m_axis_tdata_o,
  // bus_op [1:0]
  output logic [1:0]                  m_axis_tuser_o,
  // last
  output logic                        m_axis_tlast_o
);
  import cliu_pkg::*;

  logic  push;
  dec_t  push_data;
  logic  full;
  logic  pop;
  logic  head_vld;
  dec_t  head;
  res_t  res;

  // The decoder classifies the item and drops anything outside the LD group.
  cliu_front u_front (
    .s_valid_i   (s_axis_tvalid_i),
    .s_ready_o   (s_axis_tready_o),
    .s_data_i    (s_axis_tdata_i),
    .s_user_i    (s_axis_tuser_i),
    .full_i      (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  cliu_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .head_vld_o  (head_vld),
    .head_o      (head)
  );

  // The execute stage owns all architectural state and the output register.
  cliu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_vld_i  (head_vld),
    .head_i      (head),
    .pop_o       (pop),
    .res_vld_o   (m_axis_tvalid_o),
    .res_o       (res),
    .res_ready_i (m_axis_tready_i)
  );

  // Flags sit in the upper nibble of F; the lower nibble always reads zero.
  assign m_axis_tdata_o = {1'b0, res.instr_len, res.t_cycles,
                           res.regs.sp, res.regs.hl, res.regs.de, res.regs.bc,
                           res.regs.f, 4'h0, res.regs.a, res.wdata, res.addr};
  assign m_axis_tuser_o = res.bus_op;
  assign m_axis_tlast_o = res.last;

endmodule

// ===== sv/cliu_checker.sv =====
// ----------------------------------------------------------------------------
// cliu_checker: port-level checks of the load instruction execute unit
// Watches the result stream and is bound to the top level.
// ----------------------------------------------------------------------------
module cliu_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        m_axis_tvalid_o,
  input logic                        m_axis_tready_i,
  input logic [cliu_pkg::OUT_W-1:0]  m_axis_tdata_o,
  input logic [1:0]                  m_axis_tuser_o,
  input logic                        m_axis_tlast_o
);
  import cliu_pkg::*;

  // A stalled result must hold still.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) &&
      $stable(m_axis_tlast_o))
    else $error("result changed while stalled");

  // Results without a bus access always close their item.
  a_none_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == BOP_NONE |-> m_axis_tlast_o)
    else $error("bus-less result not marked last");

  // Only the first byte of the SP store leaves an item open.
  a_open_is_sp_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tlast_o |->
      m_axis_tuser_o == BOP_WR && m_axis_tdata_o[108:104] == CYC_SP_STORE)
    else $error("open result that is not the SP store");

  // The high byte of SP follows right after the low byte, one address up.
  a_sp_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o |=>
      m_axis_tvalid_o && m_axis_tlast_o && m_axis_tuser_o == BOP_WR &&
      m_axis_tdata_o[15:0] == $past(m_axis_tdata_o[15:0]) + 16'd1)
    else $error("SP store high byte missing or misplaced");

endmodule

bind cpu_load_instruction_execute_unit cliu_checker u_cliu_checker (.*);
